// ----- rtl/ple_pkg.sv -----
package ple_pkg;

    // Default pool size
    localparam int POOL_DEPTH_DEFAULT = 128;

    // Fixed field widths
    localparam int OP_W        = 3;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_PREPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_KEY = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // Outcome of one operation, handed from the sequencer to the output stage
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  read_value;
    } ple_result_t;

endpackage

// ----- rtl/ple_node_mem.sv -----
module ple_node_mem #(
    parameter int DEPTH = ple_pkg::POOL_DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int LW    = $clog2(DEPTH + 1)
) (
    input  logic                       aclk,
    input  logic                       val_we,
    input  logic [AW-1:0]              val_waddr,
    input  logic [ple_pkg::VALUE_W-1:0] val_wdata,
    input  logic                       link_we,
    input  logic [AW-1:0]              link_waddr,
    input  logic [LW-1:0]              link_wdata,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [ple_pkg::VALUE_W-1:0] rd_value,
    output logic [LW-1:0]              rd_link
);

    logic [ple_pkg::VALUE_W-1:0] value_mem [DEPTH];
    logic [LW-1:0]               link_mem  [DEPTH];
    logic [ple_pkg::VALUE_W-1:0] rd_value_reg;
    logic [LW-1:0]               rd_link_reg;

    // Write both arrays, read one node per cycle with registered data
    always_ff @(posedge aclk) begin
        if (val_we) begin
            value_mem[val_waddr] <= val_wdata;
        end
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (rd_en) begin
            rd_value_reg <= value_mem[rd_addr];
            rd_link_reg  <= link_mem[rd_addr];
        end
    end

    assign rd_value = rd_value_reg;
    assign rd_link  = rd_link_reg;

endmodule

// ----- rtl/ple_ctrl.sv -----
module ple_ctrl #(
    parameter int POOL_DEPTH = ple_pkg::POOL_DEPTH_DEFAULT,
    parameter int AW         = $clog2(POOL_DEPTH),
    parameter int IW         = $clog2(POOL_DEPTH + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Item from the input channel
    input  logic                         start,
    input  logic [ple_pkg::OP_W-1:0]     in_op,
    input  logic [ple_pkg::VALUE_W-1:0]  in_value,
    input  logic [ple_pkg::POS_W-1:0]    in_position,
    input  logic [ple_pkg::VALUE_W-1:0]  in_key,
    // Result side
    input  logic                         out_free,
    output logic                         busy,
    output logic                         done,
    output ple_pkg::ple_result_t         result,
    output logic [IW-1:0]                list_count,
    output logic [IW-1:0]                alloc_used,
    // Node memory
    output logic                         val_we,
    output logic [AW-1:0]                val_waddr,
    output logic [ple_pkg::VALUE_W-1:0]  val_wdata,
    output logic                         link_we,
    output logic [AW-1:0]                link_waddr,
    output logic [IW-1:0]                link_wdata,
    output logic                         rd_en,
    output logic [AW-1:0]                rd_addr,
    input  logic [ple_pkg::VALUE_W-1:0]  rd_value,
    input  logic [IW-1:0]                rd_link
);

    localparam logic [IW-1:0] NIL = IW'(POOL_DEPTH);
    localparam logic [IW-1:0] FULL_COUNT = IW'(POOL_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_LINK   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    localparam logic [1:0] WALK_COUNT = 2'd0;
    localparam logic [1:0] WALK_TAIL  = 2'd1;
    localparam logic [1:0] WALK_KEY   = 2'd2;

    logic [2:0]                    state_reg, state_next;
    logic [ple_pkg::OP_W-1:0]      op_reg, op_next;
    logic [ple_pkg::VALUE_W-1:0]   value_reg, value_next;
    logic [ple_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [ple_pkg::VALUE_W-1:0]   key_reg, key_next;
    logic [IW-1:0]                 cur_reg, cur_next;
    logic [IW-1:0]                 steps_reg, steps_next;
    logic [1:0]                    mode_reg, mode_next;
    logic [AW-1:0]                 slot_reg, slot_next;
    logic [IW-1:0]                 head_reg, head_next;
    logic [IW-1:0]                 alloc_reg, alloc_next;
    logic [IW-1:0]                 linked_reg, linked_next;
    logic [ple_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [ple_pkg::VALUE_W-1:0]   rdval_reg, rdval_next;

    logic                          pool_full;
    logic                          pos_neg;
    logic                          pos_gt_len;
    logic                          pos_ge_len;
    logic                          head_nil;
    logic                          link_nil;
    logic                          do_grab;
    logic                          do_front;
    logic                          do_walk;
    logic [1:0]                    walk_mode;
    logic [IW-1:0]                 walk_steps;
    logic [ple_pkg::VALUE_W-1:0]   cmp_a;
    logic [ple_pkg::VALUE_W-1:0]   cmp_b;
    logic                          cmp_hit;

    assign pool_full  = (alloc_reg == FULL_COUNT);
    assign pos_neg    = pos_reg[ple_pkg::POS_W-1];
    assign pos_gt_len = (pos_reg >  ple_pkg::POS_W'(linked_reg));
    assign pos_ge_len = (pos_reg >= ple_pkg::POS_W'(linked_reg));
    assign head_nil   = (head_reg == NIL);
    assign link_nil   = (rd_link == NIL);

    // Shared compare unit: step count, end of list or key match, by walk mode
    always_comb begin
        case (mode_reg)
            WALK_TAIL: begin
                cmp_a = ple_pkg::VALUE_W'(rd_link);
                cmp_b = ple_pkg::VALUE_W'(NIL);
            end
            WALK_KEY: begin
                cmp_a = rd_value;
                cmp_b = key_reg;
            end
            default: begin
                cmp_a = ple_pkg::VALUE_W'(steps_reg);
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_hit = (cmp_a == cmp_b);

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        value_next  = value_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        cur_next    = cur_reg;
        steps_next  = steps_reg;
        mode_next   = mode_reg;
        slot_next   = slot_reg;
        head_next   = head_reg;
        alloc_next  = alloc_reg;
        linked_next = linked_reg;
        status_next = status_reg;
        rdval_next  = rdval_reg;

        val_we      = 1'b0;
        val_waddr   = alloc_reg[AW-1:0];
        val_wdata   = value_reg;
        link_we     = 1'b0;
        link_waddr  = alloc_reg[AW-1:0];
        link_wdata  = head_reg;
        rd_en       = 1'b0;
        rd_addr     = head_reg[AW-1:0];
        done        = 1'b0;

        do_grab     = 1'b0;
        do_front    = 1'b0;
        do_walk     = 1'b0;
        walk_mode   = WALK_COUNT;
        walk_steps  = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    op_next     = in_op;
                    value_next  = in_value;
                    pos_next    = in_position;
                    key_next    = in_key;
                    status_next = ple_pkg::ST_OK;
                    rdval_next  = '0;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE: begin
                state_next = S_DONE;
                unique case (op_reg)
                    ple_pkg::OP_APPEND: begin
                        if (pool_full) begin
                            status_next = ple_pkg::ST_FULL;
                        end else begin
                            do_grab = 1'b1;
                            if (head_nil) begin
                                do_front = 1'b1;
                            end else begin
                                do_walk   = 1'b1;
                                walk_mode = WALK_TAIL;
                            end
                        end
                    end
                    ple_pkg::OP_PREPEND: begin
                        if (pool_full) begin
                            status_next = ple_pkg::ST_FULL;
                        end else begin
                            do_grab  = 1'b1;
                            do_front = 1'b1;
                        end
                    end
                    ple_pkg::OP_INS_POS: begin
                        if (pos_neg) begin
                            status_next = ple_pkg::ST_BADPOS;
                        end else if (pool_full) begin
                            status_next = ple_pkg::ST_FULL;
                        end else begin
                            do_grab = 1'b1;
                            if (pos_reg == '0) begin
                                do_front = 1'b1;
                            end else if (pos_gt_len) begin
                                // slot stays allocated but unlinked
                                status_next = ple_pkg::ST_BADPOS;
                            end else begin
                                do_walk    = 1'b1;
                                walk_mode  = WALK_COUNT;
                                walk_steps = IW'(pos_reg - ple_pkg::POS_W'(1));
                            end
                        end
                    end
                    ple_pkg::OP_INS_KEY: begin
                        if (pool_full) begin
                            status_next = ple_pkg::ST_FULL;
                        end else begin
                            do_grab = 1'b1;
                            if (head_nil) begin
                                do_front = 1'b1;
                            end else begin
                                do_walk   = 1'b1;
                                walk_mode = WALK_KEY;
                            end
                        end
                    end
                    ple_pkg::OP_READ: begin
                        if (pos_neg || pos_ge_len) begin
                            status_next = ple_pkg::ST_BADPOS;
                        end else begin
                            do_walk    = 1'b1;
                            walk_mode  = WALK_COUNT;
                            walk_steps = IW'(pos_reg);
                        end
                    end
                    default: begin
                    end
                endcase

                // Allocate the next slot and store the value
                if (do_grab) begin
                    val_we     = 1'b1;
                    slot_next  = alloc_reg[AW-1:0];
                    alloc_next = alloc_reg + IW'(1);
                end

                // Link the new slot in front of the head
                if (do_front) begin
                    link_we     = 1'b1;
                    link_wdata  = head_reg;
                    head_next   = alloc_reg;
                    linked_next = linked_reg + IW'(1);
                end

                // Start the walk at the head
                if (do_walk) begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg[AW-1:0];
                    cur_next   = head_reg;
                    mode_next  = walk_mode;
                    steps_next = walk_steps;
                    state_next = S_WALK;
                end
            end

            S_WALK: begin
                if (cmp_hit) begin
                    if (op_reg == ple_pkg::OP_READ) begin
                        rdval_next = rd_value;
                        state_next = S_DONE;
                    end else begin
                        // New node takes over the successor of the found node
                        link_we    = 1'b1;
                        link_waddr = slot_reg;
                        link_wdata = rd_link;
                        state_next = S_LINK;
                    end
                end else if (mode_reg == WALK_KEY && link_nil) begin
                    status_next = ple_pkg::ST_NOTFOUND;
                    state_next  = S_DONE;
                end else begin
                    // Advance one node
                    rd_en      = 1'b1;
                    rd_addr    = rd_link[AW-1:0];
                    cur_next   = rd_link;
                    steps_next = steps_reg - IW'(1);
                end
            end

            S_LINK: begin
                link_we     = 1'b1;
                link_waddr  = cur_reg[AW-1:0];
                link_wdata  = IW'(slot_reg);
                linked_next = linked_reg + IW'(1);
                state_next  = S_DONE;
            end

            S_DONE: begin
                if (out_free) begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            head_reg   <= NIL;
            alloc_reg  <= '0;
            linked_reg <= '0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            alloc_reg  <= alloc_next;
            linked_reg <= linked_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        value_reg  <= value_next;
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        cur_reg    <= cur_next;
        steps_reg  <= steps_next;
        mode_reg   <= mode_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
        rdval_reg  <= rdval_next;
    end

    assign busy              = (state_reg != S_IDLE);
    assign result.status     = status_reg;
    assign result.read_value = rdval_reg;
    assign list_count        = linked_reg;
    assign alloc_used        = alloc_reg;

endmodule

// ----- rtl/pool_linked_list_engine.sv -----
// Singly linked list kept in a pool of POOL_DEPTH node slots, handed out in
// order and never freed. Each transfer on the s_ channel runs one operation
// (append, prepend, insert at position, insert after key, read at position)
// and yields exactly one transfer on the m_ channel with the status and the
// list and pool counts after the operation. One item is processed at a time;
// s_ready is low while it runs. Prepend, inserts at the head and items that
// are rejected up front go from decode straight to the result; operations
// that walk the list first follow the links from the head, one link per
// cycle through the single read port of the node memory, and an insert then
// writes the link of the found node. The sequencer returns to idle before it
// takes the next transfer. The next item is accepted while a finished result
// still waits on the m_ side; a second finished result holds the sequencer
// until the first one is taken. The node memory needs no clearing after reset.
module pool_linked_list_engine #(
    parameter int POOL_DEPTH = ple_pkg::POOL_DEPTH_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [ple_pkg::OP_W-1:0]               s_op,
    input  logic signed [ple_pkg::VALUE_W-1:0]     s_value,
    input  logic signed [ple_pkg::POS_W-1:0]       s_position,
    input  logic signed [ple_pkg::VALUE_W-1:0]     s_key,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [ple_pkg::STATUS_W-1:0]           m_status,
    output logic signed [ple_pkg::VALUE_W-1:0]     m_read_value,
    output logic [ple_pkg::COUNT_OUT_W-1:0]        m_list_length,
    output logic [ple_pkg::COUNT_OUT_W-1:0]        m_pool_used
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int IW = $clog2(POOL_DEPTH + 1);

    logic                               busy;
    logic                               start;
    logic                               done;
    logic                               out_free;
    ple_pkg::ple_result_t               result;
    logic [IW-1:0]                      list_count;
    logic [IW-1:0]                      alloc_used;

    logic                               val_we;
    logic [AW-1:0]                      val_waddr;
    logic [ple_pkg::VALUE_W-1:0]        val_wdata;
    logic                               link_we;
    logic [AW-1:0]                      link_waddr;
    logic [IW-1:0]                      link_wdata;
    logic                               rd_en;
    logic [AW-1:0]                      rd_addr;
    logic [ple_pkg::VALUE_W-1:0]        rd_value;
    logic [IW-1:0]                      rd_link;

    logic                               m_valid_reg;
    logic [ple_pkg::STATUS_W-1:0]       m_status_reg;
    logic [ple_pkg::VALUE_W-1:0]        m_read_value_reg;
    logic [ple_pkg::COUNT_OUT_W-1:0]    m_list_length_reg;
    logic [ple_pkg::COUNT_OUT_W-1:0]    m_pool_used_reg;

    // Take a transfer whenever the sequencer is idle
    assign s_ready  = !busy;
    assign start    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    ple_ctrl #(
        .POOL_DEPTH (POOL_DEPTH),
        .AW         (AW),
        .IW         (IW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .in_op       (s_op),
        .in_value    (s_value),
        .in_position (s_position),
        .in_key      (s_key),
        .out_free    (out_free),
        .busy        (busy),
        .done        (done),
        .result      (result),
        .list_count  (list_count),
        .alloc_used  (alloc_used),
        .val_we      (val_we),
        .val_waddr   (val_waddr),
        .val_wdata   (val_wdata),
        .link_we     (link_we),
        .link_waddr  (link_waddr),
        .link_wdata  (link_wdata),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_value    (rd_value),
        .rd_link     (rd_link)
    );

    ple_node_mem #(
        .DEPTH (POOL_DEPTH),
        .AW    (AW),
        .LW    (IW)
    ) u_mem (
        .aclk       (aclk),
        .val_we     (val_we),
        .val_waddr  (val_waddr),
        .val_wdata  (val_wdata),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_value   (rd_value),
        .rd_link    (rd_link)
    );

    // Output valid: set on a finished item, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload: hold until the next finished item
    always_ff @(posedge aclk) begin
        if (done) begin
            m_status_reg      <= result.status;
            m_read_value_reg  <= result.read_value;
            m_list_length_reg <= ple_pkg::COUNT_OUT_W'(list_count);
            m_pool_used_reg   <= ple_pkg::COUNT_OUT_W'(alloc_used);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_list_length = m_list_length_reg;
    assign m_pool_used   = m_pool_used_reg;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int POOL_DEPTH = ple_pkg::POOL_DEPTH_DEFAULT;
    localparam int NIL_SLOT = POOL_DEPTH;
    localparam int RANDOM_ITEMS = 730;
    localparam int LONG_HOLD_CYCLES = 300;

    // Op codes the block decodes as no-ops
    localparam logic [ple_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [ple_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

    localparam logic signed [ple_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ple_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [ple_pkg::POS_W-1:0] POS_MAX = 16'sh7FFF;
    localparam logic signed [ple_pkg::POS_W-1:0] POS_MIN = 16'sh8000;

    typedef struct {
        logic [ple_pkg::OP_W-1:0]           op;
        logic signed [ple_pkg::VALUE_W-1:0] value;
        logic signed [ple_pkg::POS_W-1:0]   position;
        logic signed [ple_pkg::VALUE_W-1:0] key;
    } list_cmd_t;

    typedef struct {
        logic [ple_pkg::STATUS_W-1:0]         status;
        logic signed [ple_pkg::VALUE_W-1:0]   read_value;
        logic [ple_pkg::COUNT_OUT_W-1:0]      list_length;
        logic [ple_pkg::COUNT_OUT_W-1:0]      pool_used;
    } list_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [ple_pkg::OP_W-1:0] s_op = '0;
    logic signed [ple_pkg::VALUE_W-1:0] s_value = '0;
    logic signed [ple_pkg::POS_W-1:0] s_position = '0;
    logic signed [ple_pkg::VALUE_W-1:0] s_key = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [ple_pkg::STATUS_W-1:0] m_status;
    logic signed [ple_pkg::VALUE_W-1:0] m_read_value;
    logic [ple_pkg::COUNT_OUT_W-1:0] m_list_length;
    logic [ple_pkg::COUNT_OUT_W-1:0] m_pool_used;

    pool_linked_list_engine #(
        .POOL_DEPTH(POOL_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_value(s_value),
        .s_position(s_position),
        .s_key(s_key),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_read_value(m_read_value),
        .m_list_length(m_list_length),
        .m_pool_used(m_pool_used)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the node pool and list bookkeeping
    logic signed [ple_pkg::VALUE_W-1:0] list_vals [POOL_DEPTH];
    int list_next [POOL_DEPTH];
    int head_slot = NIL_SLOT;
    int slots_used = 0;
    int nodes_linked = 0;

    list_cmd_t cmd_q[$];
    list_result_t outcome_fifo[$];

    int n_pushed = 0;
    int n_accepted = 0;
    int n_results = 0;
    int err_count = 0;
    int quiet_from = 1 << 30;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit held_once = 1'b0;
    logic idle_ok;

    // Idle in stretches, with quiet windows and a quiet tail
    assign idle_ok = (n_accepted < quiet_from) && ((n_accepted / 48) % 3 != 2);

    task automatic flag_error(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic int follow(input int idx);
        if (idx >= POOL_DEPTH)
            return NIL_SLOT;
        return list_next[idx];
    endfunction

    function automatic int take_slot(input logic signed [ple_pkg::VALUE_W-1:0] v);
        int s;
        if (slots_used >= POOL_DEPTH)
            return NIL_SLOT;
        s = slots_used;
        list_vals[s] = v;
        list_next[s] = NIL_SLOT;
        slots_used++;
        return s;
    endfunction

    function automatic void link_head(input int s);
        list_next[s] = head_slot;
        head_slot = s;
        nodes_linked++;
    endfunction

    function automatic void link_behind(input int prev, input int s);
        list_next[s] = follow(prev);
        list_next[prev] = s;
        nodes_linked++;
    endfunction

    function automatic int node_at(input int steps);
        int cur;
        cur = head_slot;
        for (int i = 0; i < steps && i < POOL_DEPTH; i++) begin
            if (cur == NIL_SLOT)
                break;
            cur = follow(cur);
        end
        return cur;
    endfunction

    // Apply one operation to the shadow list and return the answer it gives
    function automatic list_result_t run_list_op(input list_cmd_t c);
        list_result_t r;
        int s;
        int cur;
        int p;
        int k;
        r.status = ple_pkg::ST_OK;
        r.read_value = '0;
        p = c.position;
        case (c.op)
            ple_pkg::OP_APPEND: begin
                s = take_slot(c.value);
                if (s == NIL_SLOT) begin
                    r.status = ple_pkg::ST_FULL;
                end else if (head_slot == NIL_SLOT || nodes_linked == 0) begin
                    link_head(s);
                end else begin
                    cur = head_slot;
                    for (k = 0; k < POOL_DEPTH; k++) begin
                        if (follow(cur) == NIL_SLOT)
                            break;
                        cur = follow(cur);
                    end
                    link_behind(cur, s);
                end
            end
            ple_pkg::OP_PREPEND: begin
                s = take_slot(c.value);
                if (s == NIL_SLOT)
                    r.status = ple_pkg::ST_FULL;
                else
                    link_head(s);
            end
            ple_pkg::OP_INS_POS: begin
                if (p < 0) begin
                    r.status = ple_pkg::ST_BADPOS;
                end else begin
                    s = take_slot(c.value);
                    if (s == NIL_SLOT) begin
                        r.status = ple_pkg::ST_FULL;
                    end else if (p == 0) begin
                        link_head(s);
                    end else if (p > nodes_linked) begin
                        // slot stays allocated but unlinked
                        r.status = ple_pkg::ST_BADPOS;
                    end else begin
                        cur = node_at(p - 1);
                        if (cur == NIL_SLOT)
                            r.status = ple_pkg::ST_BADPOS;
                        else
                            link_behind(cur, s);
                    end
                end
            end
            ple_pkg::OP_INS_KEY: begin
                s = take_slot(c.value);
                if (s == NIL_SLOT) begin
                    r.status = ple_pkg::ST_FULL;
                end else if (head_slot == NIL_SLOT) begin
                    link_head(s);
                end else begin
                    cur = head_slot;
                    for (k = 0; k < POOL_DEPTH; k++) begin
                        if (cur == NIL_SLOT || list_vals[cur] == c.key)
                            break;
                        cur = follow(cur);
                    end
                    if (cur == NIL_SLOT || k >= POOL_DEPTH)
                        r.status = ple_pkg::ST_NOTFOUND;
                    else
                        link_behind(cur, s);
                end
            end
            ple_pkg::OP_READ: begin
                if (p < 0 || p >= nodes_linked) begin
                    r.status = ple_pkg::ST_BADPOS;
                end else begin
                    cur = node_at(p);
                    if (cur == NIL_SLOT)
                        r.status = ple_pkg::ST_BADPOS;
                    else
                        r.read_value = list_vals[cur];
                end
            end
            default: ;
        endcase
        r.list_length = nodes_linked[ple_pkg::COUNT_OUT_W-1:0];
        r.pool_used = slots_used[ple_pkg::COUNT_OUT_W-1:0];
        return r;
    endfunction

    // Hold the input transfer until accepted, then launch the next or idle
    always @(posedge aclk) begin : drive_requests
        list_cmd_t c;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                c = cmd_q.pop_front();
                s_valid <= 1'b1;
                s_op <= c.op;
                s_value <= c.value;
                s_position <= c.position;
                s_key <= c.key;
                if (idle_ok && $urandom_range(0, 99) < 15)
                    send_gap <= $urandom_range(1, 13);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side ready: one long hold-off, then short random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
            stall_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (!held_once && n_accepted >= 60) begin
            held_once <= 1'b1;
            hold_left <= LONG_HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (idle_ok && $urandom_range(0, 99) < 10) begin
            stall_left <= $urandom_range(0, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Predict on each input transfer, check each result transfer
    always @(posedge aclk) begin : watch_ports
        list_result_t want;
        list_cmd_t c;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_results <= n_results + 1;
                if (outcome_fifo.size() == 0) begin
                    flag_error("result with nothing expected");
                end else begin
                    want = outcome_fifo.pop_front();
                    if (m_status !== want.status)
                        flag_error($sformatf("status got %0d want %0d",
                                             m_status, want.status));
                    if (m_read_value !== want.read_value)
                        flag_error($sformatf("read_value got %0d want %0d",
                                             m_read_value, want.read_value));
                    if (m_list_length !== want.list_length)
                        flag_error($sformatf("list_length got %0d want %0d",
                                             m_list_length, want.list_length));
                    if (m_pool_used !== want.pool_used)
                        flag_error($sformatf("pool_used got %0d want %0d",
                                             m_pool_used, want.pool_used));
                end
            end
            if (s_valid && s_ready) begin
                c.op = s_op;
                c.value = s_value;
                c.position = s_position;
                c.key = s_key;
                outcome_fifo.push_back(run_list_op(c));
                n_accepted <= n_accepted + 1;
            end
        end
    end

    // Queue one item, keeping the queue short so stimulus tracks list state
    task automatic push_cmd(input logic [ple_pkg::OP_W-1:0] op,
                            input logic signed [ple_pkg::VALUE_W-1:0] v,
                            input logic signed [ple_pkg::POS_W-1:0] p,
                            input logic signed [ple_pkg::VALUE_W-1:0] k);
        list_cmd_t c;
        while (cmd_q.size() > 1)
            @(posedge aclk);
        c.op = op;
        c.value = v;
        c.position = p;
        c.key = k;
        cmd_q.push_back(c);
        n_pushed++;
    endtask

    initial begin
        logic [ple_pkg::OP_W-1:0] op;
        logic signed [ple_pkg::VALUE_W-1:0] v;
        logic signed [ple_pkg::POS_W-1:0] p;
        logic signed [ple_pkg::VALUE_W-1:0] k;
        int len;
        int pick;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-list cases first, then each op and its corner cases
        push_cmd(ple_pkg::OP_INS_KEY, VAL_MAX, 16'sd0, VAL_MIN);
        push_cmd(ple_pkg::OP_READ, 32'sd0, 16'sd0, 32'sd0);
        push_cmd(ple_pkg::OP_READ, 32'sd0, 16'sd1, 32'sd0);
        push_cmd(ple_pkg::OP_READ, 32'sd0, POS_MIN, 32'sd0);
        push_cmd(ple_pkg::OP_READ, 32'sd0, POS_MAX, 32'sd0);
        push_cmd(ple_pkg::OP_APPEND, VAL_MIN, 16'sd0, 32'sd0);
        push_cmd(ple_pkg::OP_PREPEND, -32'sd1, 16'sd0, 32'sd0);
        push_cmd(ple_pkg::OP_INS_POS, 32'sd0, 16'sd0, 32'sd0);
        push_cmd(ple_pkg::OP_INS_POS, 32'sh5A5A_5A5A, 16'sd4, 32'sd0);
        push_cmd(ple_pkg::OP_INS_POS, 32'sh0000_1234, 16'sd2, 32'sd0);
        push_cmd(ple_pkg::OP_INS_POS, 32'sd7, -16'sd1, 32'sd0);
        push_cmd(ple_pkg::OP_INS_POS, 32'sd8, POS_MIN, 32'sd0);
        push_cmd(ple_pkg::OP_INS_POS, 32'sd9, POS_MAX, 32'sd0);
        push_cmd(ple_pkg::OP_INS_POS, 32'sd10, 16'sd7, 32'sd0);
        push_cmd(ple_pkg::OP_INS_KEY, 32'sd11, 16'sd0, 32'sh1234_5678);
        push_cmd(ple_pkg::OP_INS_KEY, 32'shA5A5_A5A5, 16'sd0, VAL_MIN);
        push_cmd(ple_pkg::OP_INS_KEY, 32'sd12, 16'sd0, -32'sd1);
        for (int u = OP_UNUSED_LO; u <= OP_UNUSED_HI; u++)
            push_cmd(u[ple_pkg::OP_W-1:0], $urandom, 16'($urandom), $urandom);
        push_cmd(ple_pkg::OP_READ, 32'sd0, 16'sd0, 32'sd0);
        push_cmd(ple_pkg::OP_READ, 32'sd0, 16'sd3, 32'sd0);
        push_cmd(ple_pkg::OP_READ, 32'sd0, 16'sd8, 32'sd0);
        push_cmd(ple_pkg::OP_READ, 32'sd0, 16'sd9, 32'sd0);

        quiet_from = n_pushed + RANDOM_ITEMS - 80;

        // Random: mostly reads and well-aimed inserts; the pool fills midway
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 400) begin
                while (n_results < n_pushed)
                    @(posedge aclk);
            end
            while (cmd_q.size() > 1)
                @(posedge aclk);
            len = nodes_linked;
            v = $urandom;
            p = 16'($urandom);
            k = $urandom;

            pick = $urandom_range(0, 99);
            if (pick < 6)
                op = ple_pkg::OP_APPEND;
            else if (pick < 10)
                op = ple_pkg::OP_PREPEND;
            else if (pick < 18)
                op = ple_pkg::OP_INS_POS;
            else if (pick < 26)
                op = ple_pkg::OP_INS_KEY;
            else if (pick < 30)
                op = ple_pkg::OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            else
                op = ple_pkg::OP_READ;

            case ($urandom_range(0, 9))
                0: v = VAL_MAX;
                1: v = VAL_MIN;
                2: v = -32'sd1;
                3: v = 32'sd0;
                4, 5: if (slots_used > 0) v = list_vals[$urandom_range(0, slots_used - 1)];
                default: ;
            endcase

            if (op == ple_pkg::OP_INS_KEY && slots_used > 0 && $urandom_range(0, 9) < 6)
                k = list_vals[$urandom_range(0, slots_used - 1)];

            if (op == ple_pkg::OP_INS_POS || op == ple_pkg::OP_READ) begin
                case ($urandom_range(0, 9))
                    7: p = 16'(len + ((op == ple_pkg::OP_INS_POS) ?
                                      $urandom_range(1, 3) : 0));
                    8: p = 16'(0 - $urandom_range(1, 32768));
                    9: ;
                    default: begin
                        if (op == ple_pkg::OP_INS_POS)
                            p = 16'($urandom_range(0, len));
                        else
                            p = (len > 0) ? 16'($urandom_range(0, len - 1)) : 16'sd0;
                    end
                endcase
            end
            push_cmd(op, v, p, k);
        end

        // Drain, then allow a full walk for any stray result
        while (n_results < n_pushed)
            @(posedge aclk);
        repeat (POOL_DEPTH + 20) @(posedge aclk);
        if (outcome_fifo.size() != 0)
            flag_error($sformatf("%0d expected results never arrived", outcome_fifo.size()));
        if (err_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ple_pkg.sv
rtl/ple_node_mem.sv
rtl/ple_ctrl.sv
rtl/pool_linked_list_engine.sv
tb/testbench.sv
